// ===== sv/bnit_pkg.sv =====
// Shared types and constants for the name index table.
`default_nettype none
package bnit_pkg;
   localparam logic [1:0] ACT_INSERT = 2'd0;
   localparam logic [1:0] ACT_FIND   = 2'd1;
   localparam logic [1:0] ACT_NAME   = 2'd2;
   localparam logic [1:0] ACT_NONE   = 2'd3;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_NOT_FOUND = 3'd1;
   localparam logic [2:0] ST_FULL      = 3'd2;
   localparam logic [2:0] ST_RANGE     = 3'd3;
   localparam logic [2:0] ST_DUPLICATE = 3'd4;

   localparam int KEY_W = 160;

   typedef enum logic [3:0] {
      CMD_NONE,
      CMD_START,
      CMD_PROBE,
      CMD_STEP,
      CMD_SHIFT_RD,
      CMD_SHIFT_WR,
      CMD_PLACE,
      CMD_NAME_RD,
      CMD_FINISH
   } cmd_type;

   typedef struct packed {
      logic search_done;
      logic found;
      logic shift_done;
      logic full;
      logic [1:0] action;
   } status_type;
endpackage
`default_nettype wire

// ===== sv/bidirectional_name_index_table.sv =====
// Top level of the name index table.
// A request carries an action and a 20-byte name or an entry number.
// Insert (action 0) stores the name under the next number from 1 and
// keeps a name-sorted index; action 1 binary-searches that index for a
// name; action 2 returns the name stored under a number.
// One request is worked at a time; req_tready is high only when idle.
// A search probes the index memory and then the name memory in the states
// S_READ, S_NAME and S_CMP for each probe, at most floor(log2(count))+1
// probes; an insert then shifts the sorted index by one position at a time,
// through the states S_SHRD and S_SHWR, from its end down to the insertion
// point.
// The response is held in a register until rsp_tready takes it; the
// next request is accepted the cycle after.
// Reset clears the entry count; memories keep their content but entries
// at or above the count are never returned.
`default_nettype none
module bidirectional_name_index_table
   import bnit_pkg::*;
#(
   parameter int CAPACITY = 1024
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_tvalid,
   output logic req_tready,
   // action[1:0], key_high[65:2], key_middle[129:66], key_low[161:130],
   // query_number[172:162], zero fill
   input  wire logic [175:0] req_tdata,
   output logic rsp_tvalid,
   input  wire logic rsp_tready,
   // status[2:0], entry_number[13:3], out_high[77:14], out_middle[141:78],
   // out_low[173:142], zero fill
   output logic [175:0] rsp_tdata
);
   localparam int AW = $clog2(CAPACITY);
   localparam int NW = 11;

   cmd_type cmd;
   status_type stat;
   logic idle;
   logic [2:0] res_status;
   logic [NW-1:0] res_number;
   logic [KEY_W-1:0] res_key;

   assign req_tready = idle;

   bnit_control u_ctl (
      .clock(clock), .reset(reset),
      .req_fire(req_tvalid && req_tready),
      .rsp_fire(rsp_tvalid && rsp_tready),
      .stat(stat), .cmd(cmd), .idle(idle), .rsp_valid(rsp_tvalid)
   );

   bnit_datapath #(.CAPACITY(CAPACITY), .AW(AW), .NW(NW)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd),
      .in_action(req_tdata[1:0]),
      .in_key({req_tdata[65:2], req_tdata[129:66], req_tdata[161:130]}),
      .in_number(req_tdata[172:162]),
      .stat(stat), .res_status(res_status), .res_number(res_number),
      .res_key(res_key)
   );

   assign rsp_tdata = {2'b00, res_key[31:0], res_key[95:32], res_key[159:96],
                       res_number, res_status};
endmodule
`default_nettype wire

// ===== sv/bnit_datapath.sv =====
// Datapath of the name index table: stores, sorted index, search and shift.
`default_nettype none
module bnit_datapath
   import bnit_pkg::*;
#(
   parameter int CAPACITY = 1024,
   parameter int AW = 10,
   parameter int NW = 11
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire cmd_type cmd,
   input  wire logic [1:0] in_action,
   input  wire logic [KEY_W-1:0] in_key,
   input  wire logic [NW-1:0] in_number,
   output status_type stat,
   output logic [2:0] res_status,
   output logic [NW-1:0] res_number,
   output logic [KEY_W-1:0] res_key
);
   logic [KEY_W-1:0] names [CAPACITY];
   logic [AW-1:0] order [CAPACITY];

   logic [NW-1:0] count_ff, count_in;
   logic [1:0] action_ff;
   logic [KEY_W-1:0] key_ff;
   logic [NW-1:0] number_ff;
   logic [NW:0] lo_ff, lo_in, hi_ff, hi_in;
   logic [NW-1:0] mid;
   logic [AW-1:0] slot_rd_ff;
   logic [KEY_W-1:0] name_rd_ff;
   logic found_ff, found_in;
   logic [AW-1:0] found_slot_ff, found_slot_in;
   logic [NW-1:0] ptr_ff, ptr_in;
   logic [AW-1:0] shift_val_ff;
   logic [2:0] status_ff, status_in;
   logic [NW-1:0] num_out_ff, num_out_in;
   logic [KEY_W-1:0] key_out_ff;
   logic range_bad;
   logic cmp_valid_ff;
   logic cmp_go;
   logic full_ff;

   assign mid = lo_ff[NW-1:0] + ((hi_ff[NW-1:0] - lo_ff[NW-1:0]) >> 1);
   assign range_bad = (number_ff == '0) || (number_ff > count_ff);
   assign cmp_go = cmp_valid_ff && !found_ff;

   always_ff @(posedge clock) begin
      if (cmd == CMD_START) begin
         action_ff <= in_action;
         key_ff <= in_key;
         number_ff <= in_number;
      end
      if (cmd == CMD_PROBE) slot_rd_ff <= order[mid[AW-1:0]];
      if (cmd == CMD_STEP) name_rd_ff <= names[slot_rd_ff];
      if (cmd == CMD_NAME_RD) key_out_ff <= names[number_ff[AW-1:0] - 1'b1];
      if (cmd == CMD_START) key_out_ff <= '0;
      if (cmd == CMD_SHIFT_RD) shift_val_ff <= order[ptr_ff[AW-1:0] - 1'b1];
      if (cmd == CMD_SHIFT_WR) order[ptr_ff[AW-1:0]] <= shift_val_ff;
      if (cmd == CMD_PLACE) begin
         order[ptr_ff[AW-1:0]] <= count_ff[AW-1:0];
         names[count_ff[AW-1:0]] <= key_ff;
      end
   end

   // The compare happens in the cycle after the stored name is read.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         cmp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         cmp_valid_ff <= (cmd == CMD_STEP);
      end
      lo_ff <= lo_in;
      hi_ff <= hi_in;
      found_ff <= found_in;
      found_slot_ff <= found_slot_in;
      ptr_ff <= ptr_in;
      status_ff <= status_in;
      num_out_ff <= num_out_in;
   end

   always_comb begin
      count_in = count_ff;
      lo_in = lo_ff;
      hi_in = hi_ff;
      found_in = found_ff;
      found_slot_in = found_slot_ff;
      ptr_in = ptr_ff;
      status_in = status_ff;
      num_out_in = num_out_ff;
      if (cmd == CMD_START) begin
         lo_in = '0;
         hi_in = {1'b0, count_ff};
         found_in = 1'b0;
      end
      if (cmp_go) begin
         if (name_rd_ff == key_ff) begin
            found_in = 1'b1;
            found_slot_in = slot_rd_ff;
         end else if (name_rd_ff > key_ff) begin
            hi_in = {1'b0, mid};
         end else begin
            lo_in = {1'b0, mid} + 1'b1;
         end
      end
      if (cmd == CMD_SHIFT_WR) ptr_in = ptr_ff - 1'b1;
      if (cmd == CMD_PLACE) count_in = count_ff + 1'b1;
      if (cmd == CMD_FINISH) begin
         status_in = ST_OK;
         num_out_in = '0;
         case (action_ff)
            ACT_INSERT: begin
               if (found_ff) begin
                  status_in = ST_DUPLICATE;
                  num_out_in = NW'(found_slot_ff) + 1'b1;
               end else if (count_ff == NW'(CAPACITY) + 1'b0 && !stat.full) begin
                  num_out_in = count_ff;
               end else if (stat.full) begin
                  status_in = ST_FULL;
               end else begin
                  num_out_in = count_ff;
               end
            end
            ACT_FIND: begin
               if (found_ff) num_out_in = NW'(found_slot_ff) + 1'b1;
               else status_in = ST_NOT_FOUND;
            end
            ACT_NAME: begin
               if (range_bad) status_in = ST_RANGE;
               else num_out_in = number_ff;
            end
            default: status_in = ST_RANGE;
         endcase
      end
      // Pointer starts at the end and walks down to the insertion position.
      if (cmd == CMD_START) ptr_in = count_ff;
   end

   // Insert result is decided after PLACE raises the count, so full is
   // latched at start.
   always_ff @(posedge clock) begin
      if (cmd == CMD_START) full_ff <= (count_ff == NW'(CAPACITY));
   end

   assign stat = '{search_done: found_ff || (lo_ff >= hi_ff),
                   found: found_ff,
                   shift_done: (ptr_ff == lo_ff[NW-1:0]),
                   full: full_ff,
                   action: action_ff};

   assign res_status = status_ff;
   assign res_number = num_out_ff;
   assign res_key = (action_ff == ACT_NAME && !range_bad) ? key_out_ff : '0;
endmodule
`default_nettype wire

// ===== sv/bnit_control.sv =====
// Controller state machine of the name index table.
`default_nettype none
module bnit_control
   import bnit_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_fire,
   input  wire logic rsp_fire,
   input  wire status_type stat,
   output cmd_type cmd,
   output logic idle,
   output logic rsp_valid
);
   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_DECIDE = 4'd1;
   localparam logic [3:0] S_READ = 4'd2;
   localparam logic [3:0] S_NAME = 4'd3;
   localparam logic [3:0] S_CMP = 4'd4;
   localparam logic [3:0] S_AFTER = 4'd5;
   localparam logic [3:0] S_SHRD = 4'd6;
   localparam logic [3:0] S_SHWR = 4'd7;
   localparam logic [3:0] S_FIN = 4'd8;
   localparam logic [3:0] S_OUT = 4'd9;
   localparam logic [3:0] S_NMRD = 4'd10;

   logic [3:0] state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      cmd = CMD_NONE;
      case (state_ff)
         S_IDLE: if (req_fire) begin
            cmd = CMD_START;
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            if (stat.action == ACT_NAME) state_in = S_NMRD;
            else if (stat.action == ACT_INSERT || stat.action == ACT_FIND)
               state_in = S_READ;
            else state_in = S_FIN;
         end
         S_NMRD: begin
            cmd = CMD_NAME_RD;
            state_in = S_FIN;
         end
         S_READ: begin
            if (stat.search_done) state_in = S_AFTER;
            else begin
               cmd = CMD_PROBE;
               state_in = S_NAME;
            end
         end
         S_NAME: begin
            cmd = CMD_STEP;
            state_in = S_CMP;
         end
         S_CMP: state_in = S_READ;
         S_AFTER: begin
            if (stat.action == ACT_INSERT && !stat.found && !stat.full)
               state_in = S_SHRD;
            else state_in = S_FIN;
         end
         S_SHRD: begin
            if (stat.shift_done) begin
               cmd = CMD_PLACE;
               state_in = S_FIN;
            end else begin
               cmd = CMD_SHIFT_RD;
               state_in = S_SHWR;
            end
         end
         S_SHWR: begin
            cmd = CMD_SHIFT_WR;
            state_in = S_SHRD;
         end
         S_FIN: begin
            cmd = CMD_FINISH;
            state_in = S_OUT;
         end
         S_OUT: if (rsp_fire) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   assign idle = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);

`ifndef ASSERT_OFF
   a_out_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_fire) |=> rsp_valid) else $error("response dropped");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      !idle |-> !req_fire) else $error("request taken while busy");
   a_finish_then_out: assert property (@(posedge clock) disable iff (reset)
      (cmd == CMD_FINISH) |=> rsp_valid) else $error("finish without response");
`endif
endmodule
`default_nettype wire

// ===== tb/bidirectional_name_index_table_tb.sv =====
// Testbench for the name index table: directed and random requests checked against a behavioral table.
`default_nettype none
module bidirectional_name_index_table_tb;
   import bnit_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CAP = 1024;

   typedef struct packed {
      logic [10:0] query_number;
      logic [31:0] key_low;
      logic [63:0] key_middle;
      logic [63:0] key_high;
      logic [1:0]  action;
   } request_type;

   typedef struct packed {
      logic [31:0] out_low;
      logic [63:0] out_middle;
      logic [63:0] out_high;
      logic [10:0] entry_number;
      logic [2:0]  status;
   } answer_type;

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [175:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [175:0] rsp_tdata;

   bidirectional_name_index_table #(.CAPACITY(CAP)) dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always #2 clock = ~clock;

   request_type pending_requests[$];
   answer_type  expected_answers[$];
   logic [159:0] table_names[CAP];
   int unsigned  name_count;
   int unsigned  error_count;
   int unsigned  send_gap;
   int unsigned  take_gap;
   logic [159:0] known_names[$];

   task automatic report(input string what, input logic [63:0] got,
                         input logic [63:0] want);
      error_count++;
      $display("mismatch %s: got %h expected %h", what, got, want);
   endtask

   // A linear scan gives the same answer as a search over the sorted index.
   function automatic answer_type table_answer(input request_type r);
      answer_type a;
      logic [159:0] key;
      int hit;
      a = '0;
      key = {r.key_high, r.key_middle, r.key_low};
      hit = -1;
      for (int i = 0; i < name_count; i++)
         if (table_names[i] == key) hit = i;
      case (r.action)
         ACT_INSERT: begin
            if (hit >= 0) begin
               a.status = ST_DUPLICATE;
               a.entry_number = 11'(hit + 1);
            end else if (name_count >= CAP) begin
               a.status = ST_FULL;
            end else begin
               table_names[name_count] = key;
               name_count++;
               a.entry_number = 11'(name_count);
            end
         end
         ACT_FIND: begin
            if (hit >= 0) a.entry_number = 11'(hit + 1);
            else a.status = ST_NOT_FOUND;
         end
         ACT_NAME: begin
            if (r.query_number == 0 || r.query_number > name_count) begin
               a.status = ST_RANGE;
            end else begin
               {a.out_high, a.out_middle, a.out_low} = table_names[r.query_number - 1];
               a.entry_number = r.query_number;
            end
         end
         default: a.status = ST_RANGE;
      endcase
      return a;
   endfunction

   function automatic int unsigned pick_gap();
      int unsigned p;
      p = $urandom_range(0, 99);
      if (p < 40) return 0;
      if (p < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [159:0] random_name();
      logic [159:0] n;
      int unsigned p;
      p = $urandom_range(0, 9);
      n = {$urandom, $urandom, $urandom, $urandom, $urandom};
      if (p < 4 && known_names.size() > 0)
         n = known_names[$urandom_range(0, known_names.size() - 1)];
      else if (p < 6)
         n = n >> ($urandom_range(0, 19) * 8);
      else if (p == 6 && known_names.size() > 0)
         n = known_names[$urandom_range(0, known_names.size() - 1)]
             ^ (160'd1 << $urandom_range(0, 159));
      return n;
   endfunction

   task automatic queue_request(input logic [1:0] act, input logic [159:0] name,
                                input logic [10:0] number);
      request_type r;
      r.action = act;
      {r.key_high, r.key_middle, r.key_low} = name;
      r.query_number = number;
      pending_requests.push_back(r);
      if (act == ACT_INSERT) known_names.push_back(name);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 0;
         send_gap <= 0;
      end else if (req_tvalid && !req_tready) begin
      end else if (send_gap != 0) begin
         req_tvalid <= 0;
         send_gap <= send_gap - 1;
      end else if (pending_requests.size() != 0) begin
         request_type r;
         r = pending_requests.pop_front();
         expected_answers.push_back(table_answer(r));
         req_tdata <= {3'b0, r};
         req_tvalid <= 1;
         send_gap <= pick_gap();
      end else begin
         req_tvalid <= 0;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 0;
         take_gap <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            answer_type got, want;
            got = rsp_tdata[173:0];
            if (expected_answers.size() == 0) begin
               report("unexpected response", 64'(got.status), 64'd0);
            end else begin
               want = expected_answers.pop_front();
               if (got.status !== want.status)
                  report("status", 64'(got.status), 64'(want.status));
               if (got.entry_number !== want.entry_number)
                  report("entry_number", 64'(got.entry_number), 64'(want.entry_number));
               if (got.out_high !== want.out_high)
                  report("out_high", got.out_high, want.out_high);
               if (got.out_middle !== want.out_middle)
                  report("out_middle", got.out_middle, want.out_middle);
               if (got.out_low !== want.out_low)
                  report("out_low", 64'(got.out_low), 64'(want.out_low));
            end
         end
         if (take_gap != 0) begin
            rsp_tready <= 0;
            take_gap <= take_gap - 1;
         end else begin
            rsp_tready <= 1;
            take_gap <= ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
         end
      end
   end

   initial begin
      #20ms;
      $display("bidirectional_name_index_table test failed");
      $finish;
   end

   initial begin
      int unsigned total;
      error_count = 0;
      name_count = 0;
      queue_request(ACT_FIND, {160{1'b0}}, 11'd0);
      queue_request(ACT_NAME, 160'd0, 11'd0);
      queue_request(ACT_NAME, 160'd0, 11'd1);
      queue_request(ACT_NAME, 160'd0, 11'h7ff);
      queue_request(ACT_INSERT, {160{1'b1}}, 11'h7ff);
      queue_request(ACT_INSERT, 160'd0, 11'd0);
      queue_request(ACT_INSERT, 160'h41_00_42, 11'd0);
      queue_request(ACT_INSERT, 160'h41, 11'd0);
      queue_request(ACT_INSERT, {160{1'b1}}, 11'd0);
      queue_request(ACT_FIND, 160'h41_00_42, 11'd0);
      queue_request(ACT_FIND, 160'h42, 11'd0);
      queue_request(ACT_NAME, 160'd0, 11'd1);
      queue_request(ACT_NAME, 160'd0, 11'd4);
      queue_request(ACT_NAME, 160'd0, 11'd5);
      queue_request(ACT_NONE, {160{1'b1}}, 11'h7ff);
      queue_request(ACT_NONE, 160'd0, 11'd3);
      total = 0;
      while (total < 620) begin
         int unsigned p;
         p = $urandom_range(0, 99);
         if (p < 45) queue_request(ACT_INSERT, random_name(), 11'($urandom));
         else if (p < 75) queue_request(ACT_FIND, random_name(), 11'($urandom));
         else if (p < 97) queue_request(ACT_NAME, random_name(),
            11'(($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 300)));
         else queue_request(ACT_NONE, random_name(), 11'($urandom));
         total++;
      end
      for (int i = 0; i < 60; i++) begin
         int unsigned p;
         p = $urandom_range(0, 3);
         if (p == 0) queue_request(ACT_INSERT, random_name(), 11'd0);
         else if (p == 1) queue_request(ACT_FIND, random_name(), 11'd0);
         else queue_request(ACT_NAME, 160'd0, 11'($urandom_range(0, 1025)));
      end
      queue_request(ACT_NAME, 160'd0, 11'd1024);
      queue_request(ACT_NAME, 160'd0, 11'd1025);
      repeat (10) @(posedge clock);
      reset <= 0;
      while (pending_requests.size() != 0 || expected_answers.size() != 0)
         @(posedge clock);
      repeat (3000) @(posedge clock);
      if (error_count == 0 && expected_answers.size() == 0)
         $display("bidirectional_name_index_table test passed");
      else
         $display("bidirectional_name_index_table test failed");
      $finish;
   end
endmodule
`default_nettype wire

// ===== sim.f =====
sv/bnit_pkg.sv
sv/bnit_datapath.sv
sv/bnit_control.sv
sv/bidirectional_name_index_table.sv
tb/bidirectional_name_index_table_tb.sv
